### rtl/sine_voice_with_release_decay_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sine voice unit
// Concurrent property wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SINE_VOICE_WITH_RELEASE_DECAY_UNIT_ASSERT_SVH
`define SINE_VOICE_WITH_RELEASE_DECAY_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define SVRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svrd assertion failed");
// next-cycle implication
`define SVRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svrd assertion failed");
`else
`define SVRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SVRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/svrd_pkg.sv
// ----------------------------------------------------------------------------
// svrd_pkg
// Constants, ROM contents and controller/datapath types of the sine voice.
// ----------------------------------------------------------------------------
package svrd_pkg;

    localparam int SAMPLE_RATE      = 48000;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int PHASE_BITS       = 32;

    localparam int SINE_ADDR_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int NOTE_COUNT     = 128;

    // fixed-point constants
    localparam logic [13:0] LEVEL_SCALE = 14'd9830;   // 0.15 in Q0.16
    localparam logic [15:0] DECAY_MUL   = 16'd64881;  // 0.99 in Q0.16
    localparam logic [16:0] GAIN_ONE    = 17'd65536;  // 1.0 in Q1.16
    localparam logic [16:0] GAIN_FLOOR  = 17'd327;    // 0.005 in Q1.16
    localparam logic [15:0] ROUND_HALF  = 16'd32768;

    // operation codes
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_NOTE_ON = 2'd1,
        OP_RELEASE = 2'd2,
        OP_OFF     = 2'd3
    } op_t;

    typedef logic signed [15:0]     sine_tab_t [SINE_TABLE_DEPTH];
    typedef logic [PHASE_BITS-1:0]  step_tab_t [NOTE_COUNT];

    typedef logic [19:0] oct_tab_t [12];
    localparam oct_tab_t OCTAVE0_Q16 = '{
        20'd535809, 20'd567670, 20'd601425, 20'd637188, 20'd675077, 20'd715219,
        20'd757749, 20'd802807, 20'd850544, 20'd901120, 20'd954703, 20'd1011473
    };

    // quarter-wave sine, Q30 in and out, Taylor series to 9th order
    function automatic longint unsigned quarter_sine_q30(longint unsigned u);
        longint unsigned u2;
        longint unsigned p;
        u2 = (u * u) >> 30;
        p  = 64'd172272;
        p  = 64'd5026995    - ((u2 * p) >> 30);
        p  = 64'd85569306   - ((u2 * p) >> 30);
        p  = 64'd693598668  - ((u2 * p) >> 30);
        p  = 64'd1686629713 - ((u2 * p) >> 30);
        return (u * p) >> 30;
    endfunction

    function automatic sine_tab_t build_sine();
        sine_tab_t       tab;
        longint unsigned t;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned u;
        longint unsigned v;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            t    = 64'(i) * 64'd4;
            quad = t / SINE_TABLE_DEPTH;
            rem  = t % SINE_TABLE_DEPTH;
            u    = (rem << 30) / SINE_TABLE_DEPTH;
            if (quad[0]) begin
                u = (64'd1 << 30) - u;
            end
            v = (quarter_sine_q30(u) + 64'd16384) >> 15;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            tab[i] = (quad >= 64'd2) ? -$signed(16'(v)) : $signed(16'(v));
        end
        return tab;
    endfunction

    function automatic step_tab_t build_step();
        step_tab_t       tab;
        longint unsigned num;
        int              oct;
        for (int i = 0; i < NOTE_COUNT; i++) begin
            oct    = i / 12;
            num    = 64'(OCTAVE0_Q16[i % 12]) << (oct + PHASE_BITS - 15);
            tab[i] = PHASE_BITS'(((num / SAMPLE_RATE) + 64'd1) >> 1);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_ROM = build_sine();
    localparam step_tab_t STEP_ROM = build_step();

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture the accepted transaction
        logic rom_rd;   // sine lookup and gain decay product
        logic mul1;     // sine times level
        logic mul2;     // times release gain
        logic commit;   // update voice state and load the output register
    } svrd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free; // output register can take a result this cycle
    } svrd_sts_t;

endpackage

### rtl/svrd_ctrl.sv
// ----------------------------------------------------------------------------
// svrd_ctrl
// Sequencer: steps one transaction through lookup, two multiplies and commit.
// ----------------------------------------------------------------------------
`include "sine_voice_with_release_decay_unit_assert.svh"

module svrd_ctrl
    import svrd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  svrd_sts_t sts,
    output svrd_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ROM  = 5'b00010,
        ST_MUL1 = 5'b00100,
        ST_MUL2 = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_ROM;
                end
            end
            ST_ROM: begin
                cmd.rom_rd = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SVRD_ASSERT_NXT(a_accept_starts, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_ROM)
    `SVRD_ASSERT_NOW(a_commit_needs_room, aclk, aresetn, cmd.commit, sts.out_free)
    `SVRD_ASSERT_NXT(a_done_waits, aclk, aresetn, state_reg == ST_DONE && !sts.out_free,
                     state_reg == ST_DONE)

endmodule

### rtl/svrd_dp.sv
// ----------------------------------------------------------------------------
// svrd_dp
// Voice datapath: phase accumulator, sine ROM, level and release multiplies.
// ----------------------------------------------------------------------------
`include "sine_voice_with_release_decay_unit_assert.svh"

module svrd_dp
    import svrd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  svrd_cmd_t          cmd,
    output svrd_sts_t          sts,
    input  logic [1:0]         in_operation,
    input  logic [6:0]         in_note_number,
    input  logic [15:0]        in_velocity,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_sample,
    output logic               out_voice_active,
    output logic               out_releasing
);

    localparam int PROD_W = PHASE_BITS + SINE_ADDR_BITS + 1;

    // voice state
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [PHASE_BITS-1:0] step_reg;
    logic [PHASE_BITS-1:0] step_next;
    logic [15:0]           level_reg;
    logic [15:0]           level_next;
    logic [16:0]           gain_reg;
    logic [16:0]           gain_next;

    // captured transaction
    op_t         op_reg;
    logic [6:0]  note_reg;
    logic [15:0] vel_reg;

    // intermediate results
    logic signed [15:0] sine_reg;
    logic [16:0]        gain_dec_reg;
    logic               neg_reg;
    logic [15:0]        mag1_reg;
    logic [15:0]        mag2_reg;

    // output register
    logic               out_valid_reg;
    logic signed [15:0] out_sample_reg;
    logic               out_act_reg;
    logic               out_rel_reg;

    // ROM address from the phase
    logic [PROD_W-1:0]         idx_prod;
    logic [SINE_ADDR_BITS:0]   idx_wide;
    logic [SINE_ADDR_BITS-1:0] sine_addr;

    always_comb begin
        idx_prod = {{(SINE_ADDR_BITS + 1){1'b0}}, phase_reg} * PROD_W'(SINE_TABLE_DEPTH);
        idx_wide = idx_prod[PHASE_BITS +: (SINE_ADDR_BITS + 1)];
        if (idx_wide >= (SINE_ADDR_BITS + 1)'(SINE_TABLE_DEPTH)) begin
            sine_addr = SINE_ADDR_BITS'(SINE_TABLE_DEPTH - 1);
        end else begin
            sine_addr = idx_wide[SINE_ADDR_BITS-1:0];
        end
    end

    // multiply products
    logic [33:0] gain_prod;
    logic [15:0] sine_mag;
    logic [32:0] prod1;
    logic [33:0] prod2;
    logic [30:0] level_prod;

    assign gain_prod  = {17'd0, gain_reg} * {18'd0, DECAY_MUL} + 34'(ROUND_HALF);
    assign sine_mag   = sine_reg[15] ? 16'(-sine_reg) : 16'(sine_reg);
    assign prod1      = {17'd0, sine_mag} * {17'd0, level_reg} + 33'(ROUND_HALF);
    assign prod2      = {18'd0, mag1_reg} * {17'd0, gain_reg} + 34'(ROUND_HALF);
    assign level_prod = {15'd0, vel_reg} * {17'd0, LEVEL_SCALE} + 31'(ROUND_HALF);

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= op_t'(in_operation);
            note_reg <= in_note_number;
            vel_reg  <= in_velocity;
        end
        if (cmd.rom_rd) begin
            sine_reg     <= SINE_ROM[sine_addr];
            gain_dec_reg <= gain_prod[32:16];
        end
        if (cmd.mul1) begin
            neg_reg  <= sine_reg[15];
            mag1_reg <= prod1[31:16];
        end
        if (cmd.mul2) begin
            mag2_reg <= (gain_reg != 17'd0) ? prod2[31:16] : mag1_reg;
        end
    end

    // state update on commit
    logic signed [15:0] sample_new;

    always_comb begin
        phase_next = phase_reg;
        step_next  = step_reg;
        level_next = level_reg;
        gain_next  = gain_reg;
        sample_new = '0;
        unique case (op_reg)
            OP_NOTE_ON: begin
                phase_next = '0;
                gain_next  = '0;
                level_next = {1'b0, level_prod[30:16]};
                step_next  = STEP_ROM[note_reg];
            end
            OP_RELEASE: begin
                if (step_reg != '0 && gain_reg == '0) begin
                    gain_next = GAIN_ONE;
                end
            end
            OP_OFF: begin
                step_next = '0;
                gain_next = '0;
            end
            OP_TICK: begin
                if (step_reg != '0) begin
                    sample_new = neg_reg ? -$signed(mag2_reg) : $signed(mag2_reg);
                    phase_next = phase_reg + step_reg;
                    if (gain_reg != '0) begin
                        // drop the voice once the tail is at or below the floor
                        if (gain_dec_reg <= GAIN_FLOOR) begin
                            step_next = '0;
                            gain_next = '0;
                        end else begin
                            gain_next = gain_dec_reg;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            step_reg  <= '0;
            level_reg <= '0;
            gain_reg  <= '0;
        end else if (cmd.commit) begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            level_reg <= level_next;
            gain_reg  <= gain_next;
        end
    end

    // output register: load on commit, release on handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_sample_reg <= sample_new;
            out_act_reg    <= (step_next != '0);
            out_rel_reg    <= (gain_next != '0);
        end
    end

    assign sts.out_free      = !out_valid_reg || out_ready;
    assign out_valid         = out_valid_reg;
    assign out_sample        = out_sample_reg;
    assign out_voice_active  = out_act_reg;
    assign out_releasing     = out_rel_reg;

    `SVRD_ASSERT_NOW(a_gain_bounded, aclk, aresetn, 1'b1, gain_reg <= GAIN_ONE)
    `SVRD_ASSERT_NOW(a_silent_no_release, aclk, aresetn, step_reg == '0, gain_reg == '0)
    `SVRD_ASSERT_NXT(a_commit_shows, aclk, aresetn, cmd.commit, out_valid_reg)
    `SVRD_ASSERT_NXT(a_release_flag, aclk, aresetn, cmd.commit,
                     out_rel_reg == (gain_reg != '0) && out_act_reg == (step_reg != '0))

endmodule

### rtl/sine_voice_with_release_decay_unit.sv
// ----------------------------------------------------------------------------
// sine_voice_with_release_decay_unit
// One sine voice with note on/off and an exponential release tail.
// ----------------------------------------------------------------------------
// Sequence: an accepted transaction walks the sine ROM read, the level multiply,
// the release multiply and the commit, which loads the output register. A new
// transaction is accepted only once the previous one has committed.
// A waiting result does not block acceptance; only the commit waits for room.
// Reset: synchronous active-low aresetn silences the voice and empties output.
// ----------------------------------------------------------------------------
module sine_voice_with_release_decay_unit
    import svrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [6:0] note_number, [22:7] velocity, [23] zero
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [15:0] sample, [16] voice_active, [17] releasing
);

    svrd_cmd_t          cmd;
    svrd_sts_t          sts;
    logic signed [15:0] sample;
    logic               voice_active;
    logic               releasing;

    svrd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    svrd_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .in_operation     (s_tuser),
        .in_note_number   (s_tdata[6:0]),
        .in_velocity      (s_tdata[22:7]),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_sample       (sample),
        .out_voice_active (voice_active),
        .out_releasing    (releasing)
    );

    // pack the result fields
    assign m_tdata = {6'd0, releasing, voice_active, sample};

endmodule
